### rtl/lpm_pkg.sv
// shared types, constants and helpers for the longest prefix match router
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package lpm_pkg;

   localparam int LPM_TABLE_DEPTH = 16;
   localparam int LPM_IFACE_COUNT = 16;

   localparam int ADDR_W  = 32;
   localparam int LEN_W   = 6;
   localparam int IFACE_W = 4;
   localparam int TTL_W   = 8;
   localparam int STAT_W  = 3;

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

   localparam logic FUNC_ADD   = 1'b0;
   localparam logic FUNC_ROUTE = 1'b1;

   localparam logic [STAT_W-1:0] STATUS_ADDED   = 3'd0;
   localparam logic [STAT_W-1:0] STATUS_FWD     = 3'd1;
   localparam logic [STAT_W-1:0] STATUS_TTL     = 3'd2;
   localparam logic [STAT_W-1:0] STATUS_NOROUTE = 3'd3;
   localparam logic [STAT_W-1:0] STATUS_FULL    = 3'd4;

   // one classified item as it waits between front and back
   typedef struct packed {
      logic               is_route;
      logic               expired;
      logic [ADDR_W-1:0]  prefix;
      logic [LEN_W-1:0]   prefix_len;
      logic               hop_valid;
      logic [ADDR_W-1:0]  hop;
      logic [IFACE_W-1:0] iface;
      logic [ADDR_W-1:0]  dst;
      logic [TTL_W-1:0]   ttl;
   } lpm_item_type;

   // high-order mask of len bits, len already limited to 32
   function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
      len_mask = ~({ADDR_W{1'b1}} >> len);
   endfunction

endpackage

### rtl/lpm_front.sv
// front part: takes request items, classifies them and holds them in a short queue
// depends on lpm_pkg
`timescale 1ns / 1ps

module lpm_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_func,
   input  logic [31:0]                 req_route_prefix,
   input  logic [5:0]                  req_prefix_len,
   input  logic                        req_hop_valid,
   input  logic [31:0]                 req_hop_addr,
   input  logic [3:0]                  req_iface_in,
   input  logic [31:0]                 req_dst_addr,
   input  logic [7:0]                  req_ttl_in,
   output logic                        q_valid,
   input  logic                        q_pop,
   output lpm_pkg::lpm_item_type       q_item
);
   import lpm_pkg::*;

   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   lpm_item_type       queue_ff [QUEUE_DEPTH];
   lpm_item_type       item_in;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic               push;
   logic               pop;

   // classification: saturate length, clamp interface, flag expired ttl
   always_comb begin
      item_in.is_route   = (req_func == FUNC_ROUTE);
      item_in.expired    = (req_ttl_in <= 8'd1);
      item_in.prefix     = req_route_prefix;
      item_in.prefix_len = (req_prefix_len > MAX_LEN) ? MAX_LEN : req_prefix_len;
      item_in.hop_valid  = req_hop_valid;
      item_in.hop        = req_hop_addr;
      item_in.iface      = (int'(req_iface_in) >= LPM_IFACE_COUNT) ?
                           IFACE_W'(LPM_IFACE_COUNT - 1) : req_iface_in;
      item_in.dst        = req_dst_addr;
      item_in.ttl        = req_ttl_in;
   end

   assign req_ready = (fill_ff != CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = (fill_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_item    = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? PTR_W'((int'(wr_ptr_ff) + 1) % QUEUE_DEPTH) : wr_ptr_ff;
      rd_ptr_in = pop ? PTR_W'((int'(rd_ptr_ff) + 1) % QUEUE_DEPTH) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

### rtl/lpm_back.sv
// back part: route table cells, parallel prefix compare, sorted insert, result register
// depends on lpm_pkg
`timescale 1ns / 1ps

module lpm_back #(
   parameter int TABLE_DEPTH = lpm_pkg::LPM_TABLE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   output logic                        q_pop,
   input  lpm_pkg::lpm_item_type       q_item,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [2:0]                  rsp_status,
   output logic [3:0]                  rsp_iface_out,
   output logic [31:0]                 rsp_next_hop_out,
   output logic [7:0]                  rsp_ttl_out
);
   import lpm_pkg::*;

   localparam int CW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_LOAD = 2'b01,
      ST_EXEC = 2'b10
   } back_state_type;

   back_state_type        state_ff, state_in;
   lpm_item_type          item_ff;
   logic [CW-1:0]         count_ff, count_in;

   logic [ADDR_W-1:0]     cell_prefix_ff [TABLE_DEPTH];
   logic [LEN_W-1:0]      cell_len_ff    [TABLE_DEPTH];
   logic                  cell_hv_ff     [TABLE_DEPTH];
   logic [ADDR_W-1:0]     cell_hop_ff    [TABLE_DEPTH];
   logic [IFACE_W-1:0]    cell_iface_ff  [TABLE_DEPTH];

   logic [TABLE_DEPTH-1:0] hit_in, hit_ff;
   logic [TABLE_DEPTH-1:0] gt_in, gt_ff;
   logic [TABLE_DEPTH-1:0] first_hit;
   logic [TABLE_DEPTH-1:0] shift_en;
   logic [TABLE_DEPTH-1:0] write_new;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]     status_ff, status_in;
   logic [IFACE_W-1:0]    iface_ff, iface_in;
   logic [ADDR_W-1:0]     hop_ff, hop_in;
   logic [TTL_W-1:0]      ttl_ff, ttl_in;

   logic                  fire;
   logic                  table_full;
   logic                  do_add;
   logic                  sel_hv;
   logic [ADDR_W-1:0]     sel_hop;
   logic [IFACE_W-1:0]    sel_iface;

   assign q_pop      = (state_ff == ST_LOAD) && q_valid;
   assign fire       = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign table_full = (count_ff == CW'(TABLE_DEPTH));
   assign do_add     = fire && !item_ff.is_route && !table_full;

   // per-cell compare against the item at the queue head
   genvar k;
   generate
      for (k = 0; k < TABLE_DEPTH; k++) begin : g_cmp
         localparam int PREV = (k > 0) ? k - 1 : 0;

         assign hit_in[k] = (CW'(k) < count_ff) &&
            (((q_item.dst ^ cell_prefix_ff[k]) & len_mask(cell_len_ff[k])) == '0);
         // table is sorted by length, so this vector is a run of ones up to the count
         assign gt_in[k]  = (CW'(k) < count_ff) && (q_item.prefix_len > cell_len_ff[k]);
         if (k == 0) begin : g_first
            assign shift_en[k] = 1'b0;
         end else begin : g_rest
            assign shift_en[k] = gt_ff[k-1];
         end
         assign write_new[k] = !shift_en[k] && (gt_ff[k] || (count_ff == CW'(k)));

         always_ff @(posedge clock) begin
            if (do_add && write_new[k]) begin
               cell_prefix_ff[k] <= item_ff.prefix;
               cell_len_ff[k]    <= item_ff.prefix_len;
               cell_hv_ff[k]     <= item_ff.hop_valid;
               cell_hop_ff[k]    <= item_ff.hop;
               cell_iface_ff[k]  <= item_ff.iface;
            end else if (do_add && shift_en[k]) begin
               if (k > 0) begin
                  cell_prefix_ff[k] <= cell_prefix_ff[PREV];
                  cell_len_ff[k]    <= cell_len_ff[PREV];
                  cell_hv_ff[k]     <= cell_hv_ff[PREV];
                  cell_hop_ff[k]    <= cell_hop_ff[PREV];
                  cell_iface_ff[k]  <= cell_iface_ff[PREV];
               end
            end
         end
      end
   endgenerate

   // lowest index hit has priority
   assign first_hit = hit_ff & (~hit_ff + TABLE_DEPTH'(1));

   always_comb begin
      sel_hv    = 1'b0;
      sel_hop   = '0;
      sel_iface = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         sel_hv    = sel_hv | (first_hit[i] & cell_hv_ff[i]);
         sel_hop   = sel_hop | ({ADDR_W{first_hit[i]}} & cell_hop_ff[i]);
         sel_iface = sel_iface | ({IFACE_W{first_hit[i]}} & cell_iface_ff[i]);
      end
   end

   always_comb begin
      status_in = status_ff;
      iface_in  = iface_ff;
      hop_in    = hop_ff;
      ttl_in    = ttl_ff;
      if (fire) begin
         iface_in = '0;
         hop_in   = '0;
         ttl_in   = '0;
         if (!item_ff.is_route) begin
            status_in = table_full ? STATUS_FULL : STATUS_ADDED;
         end else if (item_ff.expired) begin
            status_in = STATUS_TTL;
         end else if (hit_ff == '0) begin
            status_in = STATUS_NOROUTE;
         end else begin
            status_in = STATUS_FWD;
            iface_in  = sel_iface;
            hop_in    = sel_hv ? sel_hop : item_ff.dst;
            ttl_in    = item_ff.ttl - TTL_W'(1);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (q_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (fire) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   assign count_in     = do_add ? count_ff + CW'(1) : count_ff;
   assign rsp_valid_in = fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         item_ff <= q_item;
         hit_ff  <= hit_in;
         gt_ff   <= gt_in;
      end
      status_ff <= status_in;
      iface_ff  <= iface_in;
      hop_ff    <= hop_in;
      ttl_ff    <= ttl_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_iface_out    = iface_ff;
   assign rsp_next_hop_out = hop_ff;
   assign rsp_ttl_out      = ttl_ff;

endmodule

### rtl/longest_prefix_match_router_core.sv
// IPv4 longest prefix match router core: front classifier and queue, back route table
// Each accepted item (an add or a route) gives exactly one result item. Routes are kept
// longest prefix first, earliest added first among equal lengths; a route lookup compares
// the destination against every table cell at once and takes the first hit. The back part
// handles one item at a time: a load step takes it from the queue and compares it against
// all cells, then an execute step selects the result, updates the table and fills the
// output register, waiting while an earlier result is still uncollected. A two-item queue
// lets requests be taken while the back part is busy or a result waits to be collected.
// depends on lpm_pkg, lpm_front, lpm_back
`timescale 1ns / 1ps

module longest_prefix_match_router_core #(
   parameter int TABLE_DEPTH = lpm_pkg::LPM_TABLE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [31:0] req_route_prefix,
   input  logic [5:0]  req_prefix_len,
   input  logic        req_hop_valid,
   input  logic [31:0] req_hop_addr,
   input  logic [3:0]  req_iface_in,
   input  logic [31:0] req_dst_addr,
   input  logic [7:0]  req_ttl_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_iface_out,
   output logic [31:0] rsp_next_hop_out,
   output logic [7:0]  rsp_ttl_out
);
   import lpm_pkg::*;

   lpm_item_type q_item;
   logic         q_valid;
   logic         q_pop;

   lpm_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_route_prefix (req_route_prefix),
      .req_prefix_len   (req_prefix_len),
      .req_hop_valid    (req_hop_valid),
      .req_hop_addr     (req_hop_addr),
      .req_iface_in     (req_iface_in),
      .req_dst_addr     (req_dst_addr),
      .req_ttl_in       (req_ttl_in),
      .q_valid          (q_valid),
      .q_pop            (q_pop),
      .q_item           (q_item)
   );

   lpm_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_pop            (q_pop),
      .q_item           (q_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_iface_out    (rsp_iface_out),
      .rsp_next_hop_out (rsp_next_hop_out),
      .rsp_ttl_out      (rsp_ttl_out)
   );

endmodule
